// File: hdl/frustum_point_cube_test_defines.svh
// Assertion macros shared by the frustum test block.
`ifndef FRUSTUM_POINT_CUBE_TEST_DEFINES_SVH
`define FRUSTUM_POINT_CUBE_TEST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frustum test: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frustum test: next-cycle check failed");

`endif

// File: hdl/fpc_pkg.sv
`timescale 1ns / 1ps

package fpc_pkg;

  // Plane store geometry and fixed-point format.
  localparam int NUM_PLANES = 6;
  localparam int FRAC_BITS  = 16;
  localparam int PLANE_AW   = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  // Datapath widths: corners are one bit wider than the coordinates, and the
  // accumulator holds three full products plus the scaled constant term.
  localparam int COEF_W = 32;
  localparam int CRD_W  = COEF_W + 1;
  localparam int PROD_W = COEF_W + CRD_W;
  localparam int ACC_W  = PROD_W + 2;

  typedef struct packed {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
  } plane_t;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_POINT = 2'd1,
    ACT_CUBE  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_SUM,
    ST_CHECK,
    ST_DONE
  } state_e;

  // Sequencer controls for the shared multiply-accumulate unit.
  typedef struct packed {
    logic  init;
    logic  acc_en;
    axis_e axis;
  } mac_ctl_t;

  // Sign and zero flags of the accumulated plane value.
  typedef struct packed {
    logic neg;
    logic zero;
  } mac_sts_t;

  // Verdict handed from the sequencer to the output register.
  typedef struct packed {
    logic fin;
    logic in_view;
  } verdict_t;

endpackage

// File: hdl/fpc_plane_mem.sv
`timescale 1ns / 1ps

module fpc_plane_mem (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [fpc_pkg::PLANE_AW-1:0]        wr_addr_i,
  input  fpc_pkg::plane_t                     wr_row_i,
  input  logic [fpc_pkg::PLANE_AW-1:0]        rd_addr_i,
  output fpc_pkg::plane_t                     rd_row_o
);

  fpc_pkg::plane_t mem_q [fpc_pkg::NUM_PLANES];
  fpc_pkg::plane_t rd_row_q;

  // One whole plane per row: single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_row_q <= mem_q[rd_addr_i];
  end

  assign rd_row_o = rd_row_q;

endmodule

// File: hdl/fpc_mac.sv
`timescale 1ns / 1ps

module fpc_mac (
  input  logic                               clk_i,
  input  fpc_pkg::mac_ctl_t                  ctl_i,
  input  fpc_pkg::plane_t                    row_i,
  input  logic signed [fpc_pkg::CRD_W-1:0]   x_hi_i,
  input  logic signed [fpc_pkg::CRD_W-1:0]   x_lo_i,
  input  logic signed [fpc_pkg::CRD_W-1:0]   y_hi_i,
  input  logic signed [fpc_pkg::CRD_W-1:0]   y_lo_i,
  input  logic signed [fpc_pkg::CRD_W-1:0]   z_hi_i,
  input  logic signed [fpc_pkg::CRD_W-1:0]   z_lo_i,
  output fpc_pkg::mac_sts_t                  sts_o
);

  logic signed [fpc_pkg::COEF_W-1:0] coef;
  logic signed [fpc_pkg::CRD_W-1:0]  crd_hi;
  logic signed [fpc_pkg::CRD_W-1:0]  crd_lo;
  logic signed [fpc_pkg::CRD_W-1:0]  crd;
  logic signed [fpc_pkg::PROD_W-1:0] coef_ext;
  logic signed [fpc_pkg::PROD_W-1:0] crd_ext;
  logic signed [fpc_pkg::PROD_W-1:0] prod_d;
  logic signed [fpc_pkg::PROD_W-1:0] prod_q;
  logic signed [fpc_pkg::ACC_W-1:0]  d_scaled;
  logic signed [fpc_pkg::ACC_W-1:0]  acc_d;
  logic signed [fpc_pkg::ACC_W-1:0]  acc_q;

  // Operand selection. For a cube the corner that maximises the plane value
  // takes the upper bound where the coefficient is non-negative and the lower
  // bound otherwise; for a point both bounds hold the same coordinate.
  always_comb begin
    case (ctl_i.axis)
      fpc_pkg::AXIS_X: begin
        coef   = row_i.a;
        crd_hi = x_hi_i;
        crd_lo = x_lo_i;
      end
      fpc_pkg::AXIS_Y: begin
        coef   = row_i.b;
        crd_hi = y_hi_i;
        crd_lo = y_lo_i;
      end
      fpc_pkg::AXIS_Z: begin
        coef   = row_i.c;
        crd_hi = z_hi_i;
        crd_lo = z_lo_i;
      end
      default: begin
        coef   = row_i.a;
        crd_hi = x_hi_i;
        crd_lo = x_lo_i;
      end
    endcase
    crd      = coef[fpc_pkg::COEF_W-1] ? crd_lo : crd_hi;
    coef_ext = fpc_pkg::PROD_W'(coef);
    crd_ext  = fpc_pkg::PROD_W'(crd);
    prod_d   = coef_ext * crd_ext;
  end

  // The constant term is brought to the product format by the fraction shift.
  assign d_scaled = fpc_pkg::ACC_W'(row_i.d) <<< fpc_pkg::FRAC_BITS;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.init) begin
      acc_d = d_scaled;
    end else if (ctl_i.acc_en) begin
      acc_d = acc_q + fpc_pkg::ACC_W'(prod_q);
    end
  end

  // Product register followed by the full-width accumulator.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign sts_o.neg  = acc_q[fpc_pkg::ACC_W-1];
  assign sts_o.zero = (acc_q == '0);

endmodule

// File: hdl/fpc_ctrl.sv
`timescale 1ns / 1ps

module fpc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          cube_i,
  input  fpc_pkg::mac_sts_t             sts_i,
  input  logic                          out_free_i,
  output logic                          busy_o,
  output logic [fpc_pkg::PLANE_AW-1:0]  rd_addr_o,
  output fpc_pkg::mac_ctl_t             ctl_o,
  output fpc_pkg::verdict_t             verdict_o
);

  localparam logic [fpc_pkg::PLANE_AW-1:0] LastPlane =
    fpc_pkg::PLANE_AW'(fpc_pkg::NUM_PLANES - 1);

  fpc_pkg::state_e                state_q, state_d;
  logic [fpc_pkg::PLANE_AW-1:0]   plane_q, plane_d;
  logic                           inside_q, inside_d;
  logic                           fail;

  // A point fails a plane below zero; a cube fails where no corner is above.
  assign fail = sts_i.neg || (cube_i && sts_i.zero);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fpc_pkg::ST_IDLE;
      plane_q  <= '0;
      inside_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      plane_q  <= plane_d;
      inside_q <= inside_d;
    end
  end

  // Per plane: read the row, three multiplies, drain the last product, test.
  always_comb begin
    state_d           = state_q;
    plane_d           = plane_q;
    inside_d          = inside_q;
    ctl_o.init        = 1'b0;
    ctl_o.acc_en      = 1'b0;
    ctl_o.axis        = fpc_pkg::AXIS_X;
    verdict_o.fin     = 1'b0;
    verdict_o.in_view = inside_q;
    case (state_q)
      fpc_pkg::ST_IDLE: begin
        if (start_i) begin
          plane_d = '0;
          state_d = fpc_pkg::ST_READ;
        end
      end
      fpc_pkg::ST_READ: begin
        state_d = fpc_pkg::ST_MUL_X;
      end
      fpc_pkg::ST_MUL_X: begin
        ctl_o.init = 1'b1;
        ctl_o.axis = fpc_pkg::AXIS_X;
        state_d    = fpc_pkg::ST_MUL_Y;
      end
      fpc_pkg::ST_MUL_Y: begin
        ctl_o.acc_en = 1'b1;
        ctl_o.axis   = fpc_pkg::AXIS_Y;
        state_d      = fpc_pkg::ST_MUL_Z;
      end
      fpc_pkg::ST_MUL_Z: begin
        ctl_o.acc_en = 1'b1;
        ctl_o.axis   = fpc_pkg::AXIS_Z;
        state_d      = fpc_pkg::ST_SUM;
      end
      fpc_pkg::ST_SUM: begin
        ctl_o.acc_en = 1'b1;
        state_d      = fpc_pkg::ST_CHECK;
      end
      fpc_pkg::ST_CHECK: begin
        if (fail) begin
          inside_d = 1'b0;
          state_d  = fpc_pkg::ST_DONE;
        end else if (plane_q == LastPlane) begin
          inside_d = 1'b1;
          state_d  = fpc_pkg::ST_DONE;
        end else begin
          plane_d = plane_q + 1'b1;
          state_d = fpc_pkg::ST_READ;
        end
      end
      fpc_pkg::ST_DONE: begin
        if (out_free_i) begin
          verdict_o.fin = 1'b1;
          state_d       = fpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fpc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o    = (state_q != fpc_pkg::ST_IDLE);
  assign rd_addr_o = plane_q;

endmodule

// File: hdl/frustum_point_cube_test.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Word
// in      | input     | in_valid_i/in_stall_o | action, plane index, plane a..d,
//         |           |                       | position x..z, radius
// out     | output    | out_valid_o/out_stall_i | inside_res
//
// A plane load or an unused action gives no word. A query visits the
// planes in order, each as a row read, three products through the single
// shared multiplier, a final add and a test, and stops at the first failing
// plane, the result word appearing the cycle after the last busy one. Reset
// clears the sequencer and the output valid; the plane store is not
// cleared and must be loaded before any query. A stalled result waits in the
// output register while the next word is accepted.

`include "frustum_point_cube_test_defines.svh"

module frustum_point_cube_test (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic [2:0]         plane_index_i,
  input  logic signed [31:0] plane_a_i,
  input  logic signed [31:0] plane_b_i,
  input  logic signed [31:0] plane_c_i,
  input  logic signed [31:0] plane_d_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic [30:0]        radius_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               inside_res_o
);

  logic                                in_acc;
  logic                                is_query;
  logic                                is_cube;
  logic                                load_en;
  logic                                busy;
  logic                                out_free;
  logic [fpc_pkg::PLANE_AW-1:0]        rd_addr;
  fpc_pkg::plane_t                     wr_row;
  fpc_pkg::plane_t                     rd_row;
  fpc_pkg::mac_ctl_t                   ctl;
  fpc_pkg::mac_sts_t                   sts;
  fpc_pkg::verdict_t                   verdict;
  logic signed [fpc_pkg::CRD_W-1:0]    rad_ext;
  logic signed [fpc_pkg::CRD_W-1:0]    x_hi_q, x_lo_q, y_hi_q, y_lo_q, z_hi_q, z_lo_q;
  logic                                cube_q;
  logic                                out_valid_q;
  logic                                inside_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign is_cube  = (action_i == fpc_pkg::ACT_CUBE);
  assign is_query = (action_i == fpc_pkg::ACT_POINT) || is_cube;
  assign load_en  = in_acc && (action_i == fpc_pkg::ACT_LOAD)
                    && (32'(plane_index_i) < fpc_pkg::NUM_PLANES);
  assign out_free = !out_valid_q || !out_stall_i;

  assign wr_row.a = plane_a_i;
  assign wr_row.b = plane_b_i;
  assign wr_row.c = plane_c_i;
  assign wr_row.d = plane_d_i;

  // A point query takes the same bound on both sides of each axis.
  assign rad_ext = is_cube ? $signed({2'b00, radius_i}) : '0;

  // Corner bounds are formed one bit wider when the query word is accepted.
  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      x_hi_q <= fpc_pkg::CRD_W'(pos_x_i) + rad_ext;
      x_lo_q <= fpc_pkg::CRD_W'(pos_x_i) - rad_ext;
      y_hi_q <= fpc_pkg::CRD_W'(pos_y_i) + rad_ext;
      y_lo_q <= fpc_pkg::CRD_W'(pos_y_i) - rad_ext;
      z_hi_q <= fpc_pkg::CRD_W'(pos_z_i) + rad_ext;
      z_lo_q <= fpc_pkg::CRD_W'(pos_z_i) - rad_ext;
      cube_q <= is_cube;
    end
  end

  fpc_plane_mem u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (load_en),
    .wr_addr_i (fpc_pkg::PLANE_AW'(plane_index_i)),
    .wr_row_i  (wr_row),
    .rd_addr_i (rd_addr),
    .rd_row_o  (rd_row)
  );

  fpc_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .row_i  (rd_row),
    .x_hi_i (x_hi_q),
    .x_lo_i (x_lo_q),
    .y_hi_i (y_hi_q),
    .y_lo_i (y_lo_q),
    .z_hi_i (z_hi_q),
    .z_lo_i (z_lo_q),
    .sts_o  (sts)
  );

  fpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_acc && is_query),
    .cube_i     (cube_q),
    .sts_i      (sts),
    .out_free_i (out_free),
    .busy_o     (busy),
    .rd_addr_o  (rd_addr),
    .ctl_o      (ctl),
    .verdict_o  (verdict)
  );

  assign in_stall_o = busy;

  // Output register holds the result word until the receiver takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (verdict.fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (verdict.fin) begin
      inside_q <= verdict.in_view;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  // A query word always starts a multi-cycle walk over the planes.
  `FPC_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_acc && is_query, in_stall_o)
  // A finished verdict never overwrites a result word still waiting.
  `FPC_ASSERT_NOW(a_no_overwrite, clk_i, rst_ni, verdict.fin, !out_valid_q || !out_stall_i)
  // The plane being walked always lies within the store.
  `FPC_ASSERT_NOW(a_plane_range, clk_i, rst_ni, busy, 32'(rd_addr) < fpc_pkg::NUM_PLANES)

endmodule
